// File: rtl/dependency_readiness_scoreboard_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the dependency readiness scoreboard
// Shorthand for clocked implications disabled during an active-low reset.
// ----------------------------------------------------------------------------
`ifndef DEPENDENCY_READINESS_SCOREBOARD_UNIT_ASSERT_SVH
`define DEPENDENCY_READINESS_SCOREBOARD_UNIT_ASSERT_SVH

// Same-cycle implication
`define DRSU_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("drsu assertion failed");

// Next-cycle implication
`define DRSU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("drsu assertion failed");

`endif

// File: rtl/drsu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drsu_pkg
// Shared widths, codes and types of the dependency readiness scoreboard.
// ----------------------------------------------------------------------------
package drsu_pkg;

    localparam int unsigned MAX_ENTRIES_DEF = 64;

    localparam int unsigned IDX_W  = 6;
    localparam int unsigned STAT_W = 3;
    localparam int unsigned GEN_W  = 64;
    localparam int unsigned CNT_W  = 7;
    localparam int unsigned MASK_W = 64;
    localparam int unsigned OUT_W  = 2;
    localparam int unsigned CFG_AW = 1;
    localparam int unsigned CFG_DW = 64;

    localparam int unsigned S_TDATA_W = 80;
    localparam int unsigned M_TDATA_W = 16;

    // Status codes
    localparam logic [STAT_W-1:0] ST_PENDING   = 3'd0;
    localparam logic [STAT_W-1:0] ST_SATISFIED = 3'd1;

    // Outcome codes
    localparam logic [OUT_W-1:0] OUT_ACCEPTED = 2'd0;
    localparam logic [OUT_W-1:0] OUT_UNKNOWN  = 2'd1;
    localparam logic [OUT_W-1:0] OUT_STALE    = 2'd2;

    // Register indexes
    localparam logic [CFG_AW-1:0] CFG_ENTRY_COUNT   = 1'b0;
    localparam logic [CFG_AW-1:0] CFG_REQUIRED_MASK = 1'b1;

    // Report broadcast to every cell while a scan runs
    typedef struct packed {
        logic              known;
        logic [IDX_W-1:0]  idx;
        logic [STAT_W-1:0] status;
        logic [GEN_W-1:0]  gen;
    } t_upd;

    // Clear request from an entry_count write
    typedef struct packed {
        logic             en;
        logic [CNT_W-1:0] cnt;
    } t_clr;

    // Scan token handed from cell to cell
    typedef struct packed {
        logic             valid;
        logic             stale;
        logic             found;
        logic [IDX_W-1:0] first;
    } t_tok;

    // Result item
    typedef struct packed {
        logic [IDX_W-1:0] first;
        logic             unmet;
        logic             all_met;
        logic [OUT_W-1:0] outcome;
    } t_res;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_HOLD
    } t_state;

endpackage

// File: rtl/dependency_readiness_scoreboard_unit.sv
// The scan token walks the chain of entry cells one cell per cycle and a new
// report waits for it; the result is registered from the token leaving the
// last cell.
// A finished result sits in the output register while the next report enters.
// Reset (synchronous, active low): all entries pending with generation zero,
// entry_count and required_mask zero; no clearing pass is needed.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dependency_readiness_scoreboard_unit
// Scoreboard of dependency entries with per-entry cells in a scan chain.
// ----------------------------------------------------------------------------
module dependency_readiness_scoreboard_unit
    import drsu_pkg::*;
#(
    parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_AW-1:0]    i_cfg_addr,
    input  logic [CFG_DW-1:0]    i_cfg_wdata,
    // report stream
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // entry_index[5:0], new_status[8:6], observed_generation[72:9], zero fill
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,
    // result stream
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // outcome[1:0], all_required_met[2], unmet_found[3],
    // first_unmet_index[9:4], zero fill
    output logic [M_TDATA_W-1:0] o_m_axis_tdata
);

    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ENTRIES);

    t_state            r_state;
    t_state            n_state;
    logic [CNT_W-1:0]  r_cnt;
    logic [MASK_W-1:0] r_mask;
    t_upd              r_upd;
    logic              r_start;
    logic              r_out_valid;
    t_res              r_out;
    t_res              r_pend;

    logic              w_in_xfer;
    logic              w_out_free;
    logic              w_load;
    logic              w_from_pend;
    logic              w_pend_we;
    logic [CNT_W-1:0]  w_cnt_raw;
    logic [CNT_W-1:0]  w_cnt_sat;
    logic [IDX_W-1:0]  w_in_idx;
    t_clr              w_clr;
    t_res              w_res;
    t_tok              w_tok [MAX_ENTRIES+1];

    assign w_in_idx   = i_s_axis_tdata[IDX_W-1:0];
    assign w_in_xfer  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free = !r_out_valid || i_m_axis_tready;

    // Saturate the count and raise a clear for the entries at or above it
    always_comb begin
        w_cnt_raw = i_cfg_wdata[CNT_W-1:0];
        w_cnt_sat = (w_cnt_raw > MAX_CNT) ? MAX_CNT : w_cnt_raw;
        w_clr.en  = i_cfg_we && (i_cfg_addr == CFG_ENTRY_COUNT);
        w_clr.cnt = w_cnt_sat;
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_mask <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_ENTRY_COUNT:   r_cnt  <= w_cnt_sat;
                CFG_REQUIRED_MASK: r_mask <= i_cfg_wdata[MASK_W-1:0];
                default: ;
            endcase
        end
    end

    // Capture the report and check the index against the defined count
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_upd.known  <= {1'b0, w_in_idx} < r_cnt;
            r_upd.idx    <= w_in_idx;
            r_upd.status <= i_s_axis_tdata[IDX_W+STAT_W-1:IDX_W];
            r_upd.gen    <= i_s_axis_tdata[IDX_W+STAT_W+GEN_W-1:IDX_W+STAT_W];
        end
    end

    // Launch the scan token in the cycle after the transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= 1'b0;
        end else begin
            r_start <= w_in_xfer;
        end
    end

    // Enter the chain with a clean token
    assign w_tok[0] = {r_start, 1'b0, 1'b0, {IDX_W{1'b0}}};

    // Chain of entry cells
    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        drsu_cell #(
            .CELL_IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_upd   (r_upd),
            .i_clr   (w_clr),
            .i_req   (r_mask[g]),
            .i_cnt   (r_cnt),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
    end

    // Form the result from the token leaving the last cell
    always_comb begin
        if (!r_upd.known) begin
            w_res.outcome = OUT_UNKNOWN;
        end else if (w_tok[MAX_ENTRIES].stale) begin
            w_res.outcome = OUT_STALE;
        end else begin
            w_res.outcome = OUT_ACCEPTED;
        end
        w_res.all_met = !w_tok[MAX_ENTRIES].found;
        w_res.unmet   = w_tok[MAX_ENTRIES].found;
        w_res.first   = w_tok[MAX_ENTRIES].first;
    end

    // Sequencer: idle, scan, hold a result while the output is busy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        w_load      = 1'b0;
        w_from_pend = 1'b0;
        w_pend_we   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_tok[MAX_ENTRIES].valid) begin
                    if (w_out_free) begin
                        w_load  = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        w_pend_we = 1'b1;
                        n_state   = S_HOLD;
                    end
                end
            end
            S_HOLD: begin
                if (w_out_free) begin
                    w_load      = 1'b1;
                    w_from_pend = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_s_axis_tready = (r_state == S_IDLE);

    // Park a finished result
    always_ff @(posedge i_clk) begin
        if (w_pend_we) begin
            r_pend <= w_res;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= w_from_pend ? r_pend : w_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {(M_TDATA_W - $bits(t_res))'(0), r_out};

endmodule

// File: rtl/drsu_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drsu_cell
// One scoreboard entry: holds status and generation, applies the report as
// the scan token passes, and folds its own readiness into the token.
// ----------------------------------------------------------------------------
module drsu_cell
    import drsu_pkg::*;
#(
    parameter int unsigned CELL_IDX = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_upd             i_upd,
    input  t_clr             i_clr,
    input  logic             i_req,
    input  logic [CNT_W-1:0] i_cnt,
    input  t_tok             i_tok,
    output t_tok             o_tok
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);
    localparam logic [CNT_W-1:0] MY_POS = CNT_W'(CELL_IDX);

    logic [STAT_W-1:0] r_status;
    logic [GEN_W-1:0]  r_gen;
    t_tok              r_tok;

    logic              w_hit;
    logic              w_older;
    logic              w_wr;
    logic              w_clear;
    logic              w_unmet;
    logic [STAT_W-1:0] n_status;
    t_tok              n_tok;

    // Decide whether the passing report lands here
    always_comb begin
        w_hit    = i_tok.valid && i_upd.known && (i_upd.idx == MY_IDX);
        w_older  = i_upd.gen < r_gen;
        w_wr     = w_hit && !w_older;
        w_clear  = i_clr.en && (MY_POS >= i_clr.cnt);
        n_status = w_wr ? i_upd.status : r_status;
        w_unmet  = (MY_POS < i_cnt) && i_req && (n_status != ST_SATISFIED);
    end

    // Fold stale flag and first unmet index into the token
    always_comb begin
        n_tok.valid = i_tok.valid;
        n_tok.stale = i_tok.stale || (w_hit && w_older);
        n_tok.found = i_tok.found || w_unmet;
        n_tok.first = (i_tok.found || !w_unmet) ? i_tok.first : MY_IDX;
    end

    // Hold entry state; clear on reset or on an entry_count write at or below this index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_clear) begin
            r_status <= ST_PENDING;
            r_gen    <= '0;
        end else if (w_wr) begin
            r_status <= i_upd.status;
            r_gen    <= i_upd.gen;
        end
    end

    // Advance the token to the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

// File: rtl/drsu_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drsu_chk
// Port-level checks of the dependency readiness scoreboard, bound to the top.
// ----------------------------------------------------------------------------
`include "dependency_readiness_scoreboard_unit_assert.svh"

module drsu_chk
    import drsu_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_AW-1:0]    i_cfg_addr,
    input  logic [CFG_DW-1:0]    i_cfg_wdata,
    input  logic                 i_s_axis_tvalid,
    input  logic                 o_s_axis_tready,
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,
    input  logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    input  logic [M_TDATA_W-1:0] o_m_axis_tdata
);

    logic             w_in_xfer;
    logic [OUT_W-1:0] w_outcome;
    logic             w_all_met;
    logic             w_unmet;
    logic [IDX_W-1:0] w_first;

    assign w_in_xfer = i_s_axis_tvalid && o_s_axis_tready;
    assign w_outcome = o_m_axis_tdata[1:0];
    assign w_all_met = o_m_axis_tdata[2];
    assign w_unmet   = o_m_axis_tdata[3];
    assign w_first   = o_m_axis_tdata[9:4];

    // One report in flight: no transfer right after a transfer
    `DRSU_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, w_in_xfer, !o_s_axis_tready)
    // Readiness flags are complementary
    `DRSU_ASSERT_SAME(a_flags_excl, i_clk, i_rst_n, o_m_axis_tvalid, w_all_met != w_unmet)
    // A result with all required entries met reports index zero
    `DRSU_ASSERT_SAME(a_first_zero, i_clk, i_rst_n, o_m_axis_tvalid && w_all_met, w_first == '0)
    // Outcome is a defined code
    `DRSU_ASSERT_SAME(a_outcome_code, i_clk, i_rst_n, o_m_axis_tvalid, (w_outcome == OUT_ACCEPTED) || (w_outcome == OUT_UNKNOWN) || (w_outcome == OUT_STALE))
    // Stalled result holds
    `DRSU_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata))

endmodule

bind dependency_readiness_scoreboard_unit drsu_chk u_drsu_chk (.*);
